/* rtl/lds_pkg.sv */
// Shared types and constants for the linear diophantine solver.
// No dependencies.
`timescale 1ns / 1ps

package lds_pkg;

  // default datapath width
  localparam int WORD_BITS_DEF = 32;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_POST,
    ST_OUT
  } state_t;

  // which pass the shared divider is serving
  typedef enum logic [2:0] {
    PH_GCD,
    PH_CCHK,
    PH_RA,
    PH_RB,
    PH_RC,
    PH_EUC,
    PH_MUL
  } phase_t;

endpackage

/* rtl/linear_diophantine_solver.sv */
// Solver for a*x + b*y = c: gcd, reduction and extended Euclid on one serial divider.
// Depends on lds_pkg.
`timescale 1ns / 1ps

// Usage:
//   Input: drive in_coef_a, in_coef_b, in_rhs_c and pulse start while busy is low;
//   the transfer takes place at that edge and busy goes high on the next cycle.
//   Output: out_valid is high for exactly one cycle with out_found and the
//   solution fields x = x_base + x_step*k, y = y_base + y_step*k. The receiver
//   cannot stall; busy drops in the cycle after out_valid.
//   Schedule: each pass of the shared restoring divider is followed by one
//   bookkeeping state. A solvable item costs (n_gcd + 4 + n_euc + 1) passes,
//   where n_gcd and n_euc are the Euclid step counts (at most about 46 each
//   for 32-bit words); an item whose gcd(a,b) does not divide c costs n_gcd + 1
//   passes; a rejected item (zero or most negative operand) skips the divider
//   and goes straight to the output state. Final products s*c' and t*c' run
//   through the same unit as a divide by one with shift-add accumulation.
//   One item is in flight at a time.
//   Reset: synchronous, active low; returns the sequencer to idle and drops
//   any item in progress.
module linear_diophantine_solver
  import lds_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_coef_a,
  input  logic signed [31:0] in_coef_b,
  input  logic signed [31:0] in_rhs_c,
  output logic               out_valid,
  output logic               out_found,
  output logic signed [31:0] out_x_step,
  output logic signed [31:0] out_x_base,
  output logic signed [31:0] out_y_step,
  output logic signed [31:0] out_y_base
);

  localparam int W  = WORD_BITS;
  localparam int CW = $clog2(W + 1);
  localparam logic signed [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONE = W'(1);

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  // shared divider with shift-add accumulators
  logic [W-1:0]  dvd_r, dvd_nxt, dvs_r, dvs_nxt, rem_r, rem_nxt, quo_r, quo_nxt;
  logic [W-1:0]  accs_r, accs_nxt, acct_r, acct_nxt, ms_r, ms_nxt, mt_r, mt_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // operand magnitudes and reduced values
  logic [W-1:0] ma_r, ma_nxt, mb_r, mb_nxt, mc_r, mc_nxt, u_r, u_nxt, v_r, v_nxt;
  logic sa_r, sa_nxt, sb_r, sb_nxt, sc_r, sc_nxt;
  logic signed [W-1:0] ar_r, ar_nxt, br_r, br_nxt, cr_r, cr_nxt;

  // extended euclid state
  logic signed [W-1:0] oldr_r, oldr_nxt, r_r, r_nxt;
  logic [W-1:0] olds_r, olds_nxt, s_r, s_nxt, oldt_r, oldt_nxt, t_r, t_nxt;

  // result registers
  logic found_r, found_nxt;
  logic signed [W-1:0] xstep_r, xstep_nxt, xbase_r, xbase_nxt;
  logic signed [W-1:0] ystep_r, ystep_nxt, ybase_r, ybase_nxt;

  // inputs at word width
  logic signed [W-1:0] a_w, b_w, c_w;
  logic [W-1:0] rem_sh, quo_neg_mag, nr_mag;
  logic ge, qneg;
  logic signed [W-1:0] nr;
  logic [W-1:0] ns, nt;

  assign a_w = W'(in_coef_a);
  assign b_w = W'(in_coef_b);
  assign c_w = W'(in_rhs_c);

  // one divider step
  assign rem_sh = {rem_r[W-2:0], dvd_r[W-1]};
  assign ge     = (rem_sh >= dvs_r);

  // euclid update from a finished pass
  assign qneg        = oldr_r[W-1] ^ r_r[W-1];
  assign quo_neg_mag = '0 - rem_r;
  assign nr_mag      = oldr_r[W-1] ? quo_neg_mag : rem_r;
  assign nr          = $signed(nr_mag);
  assign ns          = qneg ? olds_r + accs_r : olds_r - accs_r;
  assign nt          = qneg ? oldt_r + acct_r : oldt_r - acct_r;

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_GCD;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
    dvd_r <= dvd_nxt;  dvs_r <= dvs_nxt;  rem_r <= rem_nxt;  quo_r <= quo_nxt;
    accs_r <= accs_nxt; acct_r <= acct_nxt; ms_r <= ms_nxt; mt_r <= mt_nxt;
    cnt_r <= cnt_nxt;
    ma_r <= ma_nxt; mb_r <= mb_nxt; mc_r <= mc_nxt; u_r <= u_nxt; v_r <= v_nxt;
    sa_r <= sa_nxt; sb_r <= sb_nxt; sc_r <= sc_nxt;
    ar_r <= ar_nxt; br_r <= br_nxt; cr_r <= cr_nxt;
    oldr_r <= oldr_nxt; r_r <= r_nxt;
    olds_r <= olds_nxt; s_r <= s_nxt; oldt_r <= oldt_nxt; t_r <= t_nxt;
    found_r <= found_nxt;
    xstep_r <= xstep_nxt; xbase_r <= xbase_nxt;
    ystep_r <= ystep_nxt; ybase_r <= ybase_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;  phase_nxt = phase_r;
    dvd_nxt = dvd_r;  dvs_nxt = dvs_r;  rem_nxt = rem_r;  quo_nxt = quo_r;
    accs_nxt = accs_r; acct_nxt = acct_r; ms_nxt = ms_r; mt_nxt = mt_r;
    cnt_nxt = cnt_r;
    ma_nxt = ma_r; mb_nxt = mb_r; mc_nxt = mc_r; u_nxt = u_r; v_nxt = v_r;
    sa_nxt = sa_r; sb_nxt = sb_r; sc_nxt = sc_r;
    ar_nxt = ar_r; br_nxt = br_r; cr_nxt = cr_r;
    oldr_nxt = oldr_r; r_nxt = r_r;
    olds_nxt = olds_r; s_nxt = s_r; oldt_nxt = oldt_r; t_nxt = t_r;
    found_nxt = found_r;
    xstep_nxt = xstep_r; xbase_nxt = xbase_r;
    ystep_nxt = ystep_r; ybase_nxt = ybase_r;

    // a new divider pass always starts from a clean remainder
    if (state_r != ST_DIV) begin
      rem_nxt  = '0;
      quo_nxt  = '0;
      accs_nxt = '0;
      acct_nxt = '0;
      cnt_nxt  = CW'(W);
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          sa_nxt = a_w[W-1];
          sb_nxt = b_w[W-1];
          sc_nxt = c_w[W-1];
          ma_nxt = a_w[W-1] ? W'(-a_w) : W'(a_w);
          mb_nxt = b_w[W-1] ? W'(-b_w) : W'(b_w);
          mc_nxt = c_w[W-1] ? W'(-c_w) : W'(c_w);
          if (a_w == '0 || b_w == '0 || c_w == '0 ||
              a_w == MINW || b_w == MINW || c_w == MINW) begin
            found_nxt = 1'b0;
            xstep_nxt = MINW; xbase_nxt = MINW;
            ystep_nxt = MINW; ybase_nxt = MINW;
            state_nxt = ST_OUT;
          end else begin
            // first gcd pass: |a| by |b|
            u_nxt     = a_w[W-1] ? W'(-a_w) : W'(a_w);
            v_nxt     = b_w[W-1] ? W'(-b_w) : W'(b_w);
            dvd_nxt   = a_w[W-1] ? W'(-a_w) : W'(a_w);
            dvs_nxt   = b_w[W-1] ? W'(-b_w) : W'(b_w);
            ms_nxt    = '0;
            mt_nxt    = '0;
            phase_nxt = PH_GCD;
            state_nxt = ST_DIV;
          end
        end
      end

      ST_DIV: begin
        rem_nxt  = ge ? rem_sh - dvs_r : rem_sh;
        quo_nxt  = {quo_r[W-2:0], ge};
        dvd_nxt  = {dvd_r[W-2:0], 1'b0};
        accs_nxt = {accs_r[W-2:0], 1'b0} + (ge ? ms_r : '0);
        acct_nxt = {acct_r[W-2:0], 1'b0} + (ge ? mt_r : '0);
        cnt_nxt  = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) state_nxt = ST_POST;
      end

      ST_POST: begin
        state_nxt = ST_DIV;
        case (phase_r)
          PH_GCD: begin
            u_nxt = v_r;
            v_nxt = rem_r;
            if (rem_r == '0) begin
              // gcd(a,b) found in v; test whether it divides c
              dvd_nxt   = mc_r;
              dvs_nxt   = v_r;
              phase_nxt = PH_CCHK;
            end else begin
              dvd_nxt = v_r;
              dvs_nxt = rem_r;
            end
          end
          PH_CCHK: begin
            if (rem_r != '0) begin
              found_nxt = 1'b0;
              xstep_nxt = MINW; xbase_nxt = MINW;
              ystep_nxt = MINW; ybase_nxt = MINW;
              state_nxt = ST_OUT;
            end else begin
              // gcd(a,b) divides c, so it is also gcd(a,b,c)
              dvd_nxt   = ma_r;
              phase_nxt = PH_RA;
            end
          end
          PH_RA: begin
            ar_nxt    = sa_r ? $signed('0 - quo_r) : $signed(quo_r);
            dvd_nxt   = mb_r;
            phase_nxt = PH_RB;
          end
          PH_RB: begin
            br_nxt    = sb_r ? $signed('0 - quo_r) : $signed(quo_r);
            dvd_nxt   = mc_r;
            phase_nxt = PH_RC;
          end
          PH_RC: begin
            cr_nxt   = sc_r ? $signed('0 - quo_r) : $signed(quo_r);
            oldr_nxt = ar_r;
            r_nxt    = br_r;
            olds_nxt = ONE;
            s_nxt    = '0;
            oldt_nxt = '0;
            t_nxt    = ONE;
            dvd_nxt  = ar_r[W-1] ? W'(-ar_r) : W'(ar_r);
            dvs_nxt  = br_r[W-1] ? W'(-br_r) : W'(br_r);
            ms_nxt   = '0;
            mt_nxt   = ONE;
            phase_nxt = PH_EUC;
          end
          PH_EUC: begin
            oldr_nxt = r_r;
            r_nxt    = nr;
            olds_nxt = s_r;
            s_nxt    = ns;
            oldt_nxt = t_r;
            t_nxt    = nt;
            if (nr == '0) begin
              // products s*c' and t*c' as a divide by one
              dvd_nxt   = cr_r;
              dvs_nxt   = ONE;
              ms_nxt    = s_r;
              mt_nxt    = t_r;
              phase_nxt = PH_MUL;
            end else begin
              // next pass divides |r| by the magnitude of the new remainder
              dvd_nxt = r_r[W-1] ? W'(-r_r) : W'(r_r);
              dvs_nxt = rem_r;
              ms_nxt  = ns;
              mt_nxt  = nt;
            end
          end
          PH_MUL: begin
            found_nxt = 1'b1;
            xstep_nxt = br_r;
            ystep_nxt = W'(-ar_r);
            xbase_nxt = oldr_r[W-1] ? $signed('0 - accs_r) : $signed(accs_r);
            ybase_nxt = oldr_r[W-1] ? $signed('0 - acct_r) : $signed(acct_r);
            state_nxt = ST_OUT;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end

      ST_OUT: state_nxt = ST_IDLE;

      default: state_nxt = ST_IDLE;
    endcase
  end

  // ports
  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = (state_r == ST_OUT);
  assign out_found  = found_r;
  assign out_x_step = 32'(xstep_r);
  assign out_x_base = 32'(xbase_r);
  assign out_y_step = 32'(ystep_r);
  assign out_y_base = 32'(ybase_r);

endmodule

/* rtl/lds_checker.sv */
// Port-level checks for linear_diophantine_solver, attached by bind.
// Depends on the solver's port list only.
`timescale 1ns / 1ps

module lds_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic        out_found,
  input logic [31:0] out_x_step,
  input logic [31:0] out_y_step
);

  // a result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("out_valid held longer than one cycle");

  // an accepted transfer makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy not raised after transfer");

  // a result is only shown while busy
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("out_valid while idle");

  // busy ends only right after a result
  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> $past(out_valid))
    else $error("busy dropped without a result");

  // a solvable equation has nonzero steps
  a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_x_step != '0 && out_y_step != '0))
    else $error("zero step in a found solution");

endmodule

bind linear_diophantine_solver lds_checker u_lds_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_found  (out_found),
  .out_x_step (out_x_step),
  .out_y_step (out_y_step)
);

/* tb/linear_diophantine_solver_test.sv */
// Self-checking testbench for linear_diophantine_solver: directed and random equations.
// Depends on lds_pkg and linear_diophantine_solver; predicts each result internally.
`timescale 1ns / 1ps

module linear_diophantine_solver_test;
  import lds_pkg::*;

  localparam int CYCLE_LIMIT = 10000000;
  localparam int NUM_RANDOM = 300;
  localparam logic [31:0] MOST_NEG = 32'h8000_0000;

  typedef struct packed {
    logic        found;
    logic [31:0] x_step;
    logic [31:0] x_base;
    logic [31:0] y_step;
    logic [31:0] y_base;
  } solution_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [31:0] in_coef_a;
  logic signed [31:0] in_coef_b;
  logic signed [31:0] in_rhs_c;
  logic out_valid;
  logic out_found;
  logic signed [31:0] out_x_step;
  logic signed [31:0] out_x_base;
  logic signed [31:0] out_y_step;
  logic signed [31:0] out_y_base;

  solution_t expected_solutions[$];
  int error_count;
  int cycle_count;
  int burst_left;

  linear_diophantine_solver uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_coef_a(in_coef_a), .in_coef_b(in_coef_b), .in_rhs_c(in_rhs_c),
    .out_valid(out_valid), .out_found(out_found),
    .out_x_step(out_x_step), .out_x_base(out_x_base),
    .out_y_step(out_y_step), .out_y_base(out_y_base)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // timeout watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // unsigned euclid on magnitudes
  function automatic logic [63:0] gcd_mag(logic [63:0] p, logic [63:0] q);
    logic [63:0] rem;
    while (q != 0) begin
      rem = p % q;
      p = q;
      q = rem;
    end
    return p;
  endfunction

  // expected solution for one equation
  function automatic solution_t solve_equation(logic [31:0] a_in, logic [31:0] b_in,
                                               logic [31:0] c_in);
    solution_t res;
    longint a, b, c, ar, br, cr, prev_r, cur_r, quo, nxt;
    longint unsigned gab, g, prev_s, cur_s, prev_t, cur_t, tmp;
    a = longint'($signed(a_in));
    b = longint'($signed(b_in));
    c = longint'($signed(c_in));
    res.found = 1'b0;
    res.x_step = MOST_NEG;
    res.x_base = MOST_NEG;
    res.y_step = MOST_NEG;
    res.y_base = MOST_NEG;
    if (a == 0 || b == 0 || c == 0) return res;
    if (a_in == MOST_NEG || b_in == MOST_NEG || c_in == MOST_NEG) return res;
    gab = gcd_mag(a < 0 ? -a : a, b < 0 ? -b : b);
    if ((c < 0 ? -c : c) % gab != 0) return res;
    g = gcd_mag(gab, c < 0 ? -c : c);
    ar = a / longint'(g);
    br = b / longint'(g);
    cr = c / longint'(g);
    prev_r = ar;
    cur_r = br;
    prev_s = 1;
    cur_s = 0;
    prev_t = 0;
    cur_t = 1;
    // extended euclid with truncating quotients
    while (cur_r != 0) begin
      quo = prev_r / cur_r;
      nxt = prev_r - quo * cur_r;
      prev_r = cur_r;
      cur_r = nxt;
      tmp = prev_s - longint'(quo) * cur_s;
      prev_s = cur_s;
      cur_s = tmp;
      tmp = prev_t - longint'(quo) * cur_t;
      prev_t = cur_t;
      cur_t = tmp;
    end
    res.found = 1'b1;
    res.x_step = br[31:0];
    tmp = prev_s * longint'(prev_r) * longint'(cr);
    res.x_base = tmp[31:0];
    tmp = 0 - ar;
    res.y_step = tmp[31:0];
    tmp = prev_t * longint'(prev_r) * longint'(cr);
    res.y_base = tmp[31:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    solution_t want;
    if (rst_n && out_valid) begin
      if (expected_solutions.size() == 0) begin
        report_mismatch("unexpected result", {31'b0, out_found}, 32'b0);
      end else begin
        want = expected_solutions.pop_front();
        if (out_found !== want.found)
          report_mismatch("found", {31'b0, out_found}, {31'b0, want.found});
        if (out_x_step !== want.x_step) report_mismatch("x_step", out_x_step, want.x_step);
        if (out_x_base !== want.x_base) report_mismatch("x_base", out_x_base, want.x_base);
        if (out_y_step !== want.y_step) report_mismatch("y_step", out_y_step, want.y_step);
        if (out_y_base !== want.y_base) report_mismatch("y_base", out_y_base, want.y_base);
      end
    end
  end

  // one equation transfer, with bursty gaps between transfers
  task automatic send_equation(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    in_coef_a <= a;
    in_coef_b <= b;
    in_rhs_c <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_solutions.push_back(solve_equation(a, b, c));
    @(negedge clk);
  endtask

  task automatic test_rejections();
    send_equation(0, 3, 5);
    send_equation(3, 0, 5);
    send_equation(3, 5, 0);
    send_equation(MOST_NEG, 3, 5);
    send_equation(3, MOST_NEG, 5);
    send_equation(3, 5, MOST_NEG);
    send_equation(4, 6, 7);
    send_equation(32'hffff_fffe, 10, 1);
  endtask

  task automatic test_solvable();
    send_equation(3, 5, 1);
    send_equation(4, 6, 8);
    send_equation(-4, 6, -2);
    send_equation(1, 1, 1);
    send_equation(-1, -1, -1);
    send_equation(32'h7fff_ffff, 32'h7fff_fffe, 32'h7fff_ffff);
    send_equation(32'h8000_0001, 32'h7fff_ffff, 32'h8000_0001);
    send_equation(1134903170, 1836311903, 32'h7fff_fff3);
    send_equation(-1134903170, 1836311903, -1);
    send_equation(6, 6, 6);
    send_equation(12, -18, 30);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 40) - 20;
      1: return MOST_NEG + $urandom_range(0, 2);
      2: return 32'h7fff_ffff - $urandom_range(0, 2);
      3: return $urandom_range(1, 1000) * ($urandom_range(0, 1) ? -1 : 1);
      default: return $urandom;
    endcase
  endfunction

  // random equations; most share a factor, which tends to make them solvable
  task automatic test_random();
    logic [31:0] a, b, c, f;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if ($urandom_range(0, 3) != 0) begin
        f = $urandom_range(1, 50);
        a = (rand_operand() >>> 8) * f;
        b = (rand_operand() >>> 8) * f;
        c = ((rand_operand() >>> 8) * f) | 32'($urandom_range(0, 9) == 0);
      end else begin
        a = rand_operand();
        b = rand_operand();
        c = rand_operand();
      end
      send_equation(a, b, c);
    end
  endtask

  initial begin
    int drain;
    rst_n = 1'b0;
    start = 1'b0;
    in_coef_a = '0;
    in_coef_b = '0;
    in_rhs_c = '0;
    error_count = 0;
    cycle_count = 0;
    burst_left = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_rejections();
    test_solvable();
    test_random();
    start <= 1'b0;
    while (expected_solutions.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < 50) begin
      @(posedge clk);
      drain++;
    end
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
